@@ rtl/tbps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbps_pkg
// Shared constants and codes for the timed bit pattern sequencer.
// ----------------------------------------------------------------------------
package tbps_pkg;

   localparam int SLOTS_DEFAULT     = 8;
   localparam int WORD_BITS_DEFAULT = 32;

   localparam int ACTION_W    = 2;
   localparam int SLOT_IDX_W  = 3;
   localparam int SLOT_WORD_W = 32;
   localparam int SLOT_LIFE_W = 8;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam int BPW_CFG_W   = 6;
   localparam int SCNT_CFG_W  = 4;
   localparam int REP_CFG_W   = 8;
   localparam int TICKS_CFG_W = 32;
   localparam int DUMMY_CFG_W = 16;

   localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RESTART = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BITS_PER_WORD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_COUNT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STATE_TICKS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DUMMY_COUNT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DUMMY_LEVEL   = 3'd5;

   localparam logic [BPW_CFG_W-1:0]  BPW_RESET  = 6'd32;
   localparam logic [SCNT_CFG_W-1:0] SCNT_RESET = 4'd1;

endpackage
`default_nettype wire

@@ rtl/tbps_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbps channel interfaces
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tbps_req_if;
   logic                             valid;
   logic                             ready;
   logic [tbps_pkg::ACTION_W-1:0]    action;
   logic [tbps_pkg::SLOT_IDX_W-1:0]  slot_index;
   logic [tbps_pkg::SLOT_WORD_W-1:0] slot_word;
   logic [tbps_pkg::SLOT_LIFE_W-1:0] slot_life;

   modport source (output valid, action, slot_index, slot_word, slot_life, input ready);
   modport sink   (input valid, action, slot_index, slot_word, slot_life, output ready);
endinterface

interface tbps_rsp_if;
   logic valid;
   logic ready;
   logic pin_level;
   logic pin_written;
   logic round_done;

   modport source (output valid, pin_level, pin_written, round_done, input ready);
   modport sink   (input valid, pin_level, pin_written, round_done, output ready);
endinterface

interface tbps_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tbps_pkg::CSR_IDX_W-1:0]  index;
   logic [tbps_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/tbps_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbps_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tbps_div #(
   parameter int W = 17
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              done,
   output logic [W-1:0]      quot,
   output logic [W-1:0]      rem
);

   localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

   logic             run_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [W-1:0]     quot_ff;
   logic [W-1:0]     rem_ff;
   logic [W-1:0]     dvs_ff;
   logic [W:0]       shifted;
   logic             fits;

   assign shifted = {rem_ff, quot_ff[W-1]};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            cnt_ff  <= '0;
            quot_ff <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
         end else if (run_ff) begin
            quot_ff <= {quot_ff[W-2:0], fits};
            rem_ff  <= fits ? W'(shifted - {1'b0, dvs_ff}) : shifted[W-1:0];
            cnt_ff  <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(W - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
   assign rem  = rem_ff;

endmodule
`default_nettype wire

@@ rtl/timed_bit_pattern_sequencer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Steps: write, restart, quiet tick or round start go from IDLE to FIN, which registers the result.
// Dummy state or round end: MUL_ACT, MUL_PLAY, CMP, FIN; pattern bit: MUL_ACT, MUL_PLAY, CMP,
// DIV_BIT, DIV_SLOT, FIN, two passes through the shared bit-serial divider (bit and slot index).
// One item at a time; the next request is taken as soon as the result is registered.
// Synchronous active-high reset clears slots, lifetimes, position, elapsed count,
// pin level and registers to their reset values.
// ----------------------------------------------------------------------------
// timed_bit_pattern_sequencer_core
// Drives one pin level from slot words, MSB first, with state timing,
// repeats, dummy states and slot lifetime ageing at the end of each round.
// ----------------------------------------------------------------------------
module timed_bit_pattern_sequencer_core #(
   parameter int SLOTS     = tbps_pkg::SLOTS_DEFAULT,
   parameter int WORD_BITS = tbps_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   tbps_req_if.sink   req_ch,
   tbps_rsp_if.source rsp_ch,
   tbps_csr_if.sink   csr_ch
);

   localparam int BPW_W   = $clog2(WORD_BITS + 1);
   localparam int SCNT_W  = $clog2(SLOTS + 1);
   localparam int SIDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BIDX_W  = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
   localparam int ACT_W   = BPW_W + SCNT_W;
   localparam int REP_W   = tbps_pkg::REP_CFG_W + 1;
   localparam int PLAY_W  = ACT_W + REP_W;
   localparam int TOT_W   = ((ACT_W > tbps_pkg::DUMMY_CFG_W) ? ACT_W : tbps_pkg::DUMMY_CFG_W) + 1;
   localparam int MAX_PLAY = SLOTS * WORD_BITS * 256;
   localparam int MAX_TOT  = SLOTS * WORD_BITS + 65535;
   localparam int MAX_POS  = (MAX_PLAY > MAX_TOT) ? MAX_PLAY : MAX_TOT;
   localparam int POS_W   = $clog2(MAX_POS + 1);
   localparam int CMP_W0  = (PLAY_W > TOT_W) ? PLAY_W : TOT_W;
   localparam int CMP_W   = (CMP_W0 > POS_W) ? CMP_W0 : POS_W;
   localparam int DIV_W   = POS_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_ACT,
      S_MUL_PLAY,
      S_CMP,
      S_DIV_BIT,
      S_DIV_SLOT,
      S_FIN
   } state_type;

   state_type state_ff;

   logic [tbps_pkg::BPW_CFG_W-1:0]   cfg_bpw_ff;
   logic [tbps_pkg::SCNT_CFG_W-1:0]  cfg_scnt_ff;
   logic [tbps_pkg::REP_CFG_W-1:0]   cfg_rep_ff;
   logic [tbps_pkg::TICKS_CFG_W-1:0] cfg_ticks_ff;
   logic [tbps_pkg::DUMMY_CFG_W-1:0] cfg_dummy_ff;
   logic                             cfg_dlevel_ff;

   logic [WORD_BITS-1:0]             words_ff [SLOTS];
   logic [tbps_pkg::SLOT_LIFE_W-1:0] lives_ff [SLOTS];

   logic [POS_W-1:0]  pos_ff;
   logic [31:0]       elapsed_ff;
   logic [31:0]       elapsed_in;
   logic              level_ff;
   logic              written_ff;
   logic              done_ff;
   logic [ACT_W-1:0]  active_ff;
   logic [PLAY_W-1:0] played_ff;
   logic [TOT_W-1:0]  total_ff;
   logic [BIDX_W-1:0] bitsel_ff;

   logic rsp_valid_ff;
   logic rsp_level_ff;
   logic rsp_written_ff;
   logic rsp_done_ff;

   logic [BPW_W-1:0]  bpw_eff;
   logic [SCNT_W-1:0] slot_eff;
   logic [BPW_W-1:0]  top_bit;
   logic [BPW_W-1:0]  bit_from_rem;
   logic [REP_W-1:0]  rep_plus;
   logic              in_pattern;
   logic              in_round;
   logic              req_fire;
   logic              tick_adv;

   logic             div_start;
   logic [DIV_W-1:0] div_dividend;
   logic [DIV_W-1:0] div_divisor;
   logic             div_done;
   logic [DIV_W-1:0] div_quot;
   logic [DIV_W-1:0] div_rem;

   logic [WORD_BITS+tbps_pkg::SLOT_WORD_W-1:0] word_ext;
   logic [SIDX_W+tbps_pkg::SLOT_IDX_W-1:0]     idx_ext;

   always_comb begin
      if (cfg_bpw_ff == '0) begin
         bpw_eff = BPW_W'(1);
      end else if (32'(cfg_bpw_ff) > 32'(WORD_BITS)) begin
         bpw_eff = BPW_W'(WORD_BITS);
      end else begin
         bpw_eff = BPW_W'(cfg_bpw_ff);
      end
      if (cfg_scnt_ff == '0) begin
         slot_eff = SCNT_W'(1);
      end else if (32'(cfg_scnt_ff) > 32'(SLOTS)) begin
         slot_eff = SCNT_W'(SLOTS);
      end else begin
         slot_eff = SCNT_W'(cfg_scnt_ff);
      end
   end

   assign top_bit      = bpw_eff - BPW_W'(1);
   assign bit_from_rem = bpw_eff - BPW_W'(1) - div_rem[BPW_W-1:0];
   assign rep_plus     = {1'b0, cfg_rep_ff} + REP_W'(1);
   assign in_pattern   = CMP_W'(pos_ff) < CMP_W'(played_ff);
   assign in_round     = CMP_W'(pos_ff) < CMP_W'(total_ff);
   assign elapsed_in   = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 32'd1;
   assign tick_adv     = elapsed_in > cfg_ticks_ff;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign word_ext     = {{WORD_BITS{1'b0}}, req_ch.slot_word};
   assign idx_ext      = {{SIDX_W{1'b0}}, req_ch.slot_index};

   always_comb begin
      div_start    = 1'b0;
      div_dividend = DIV_W'(pos_ff);
      div_divisor  = DIV_W'(bpw_eff);
      case (state_ff)
         S_CMP: begin
            div_start = in_pattern;
         end
         S_DIV_BIT: begin
            div_start    = div_done;
            div_dividend = div_quot;
            div_divisor  = DIV_W'(slot_eff);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   tbps_div #(
      .W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_bpw_ff    <= tbps_pkg::BPW_RESET;
         cfg_scnt_ff   <= tbps_pkg::SCNT_RESET;
         cfg_rep_ff    <= '0;
         cfg_ticks_ff  <= '0;
         cfg_dummy_ff  <= '0;
         cfg_dlevel_ff <= 1'b0;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            tbps_pkg::CSR_BITS_PER_WORD: cfg_bpw_ff    <= csr_ch.data[tbps_pkg::BPW_CFG_W-1:0];
            tbps_pkg::CSR_SLOT_COUNT:    cfg_scnt_ff   <= csr_ch.data[tbps_pkg::SCNT_CFG_W-1:0];
            tbps_pkg::CSR_REPEAT_COUNT:  cfg_rep_ff    <= csr_ch.data[tbps_pkg::REP_CFG_W-1:0];
            tbps_pkg::CSR_STATE_TICKS:   cfg_ticks_ff  <= csr_ch.data[tbps_pkg::TICKS_CFG_W-1:0];
            tbps_pkg::CSR_DUMMY_COUNT:   cfg_dummy_ff  <= csr_ch.data[tbps_pkg::DUMMY_CFG_W-1:0];
            tbps_pkg::CSR_DUMMY_LEVEL:   cfg_dlevel_ff <= csr_ch.data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         elapsed_ff   <= '0;
         level_ff     <= 1'b0;
         written_ff   <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            words_ff[i] <= '0;
            lives_ff[i] <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && state_ff != S_FIN) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  written_ff <= 1'b0;
                  done_ff    <= 1'b0;
                  state_ff   <= S_FIN;
                  case (req_ch.action)
                     tbps_pkg::ACT_TICK: begin
                        if (pos_ff == '0) begin
                           elapsed_ff <= '0;
                           level_ff   <= words_ff[0][top_bit[BIDX_W-1:0]];
                           written_ff <= 1'b1;
                           pos_ff     <= POS_W'(1);
                        end else if (tick_adv) begin
                           elapsed_ff <= '0;
                           state_ff   <= S_MUL_ACT;
                        end else begin
                           elapsed_ff <= elapsed_in;
                        end
                     end
                     tbps_pkg::ACT_WRITE: begin
                        if (32'(req_ch.slot_index) < 32'(SLOTS)) begin
                           words_ff[idx_ext[SIDX_W-1:0]] <= word_ext[WORD_BITS-1:0];
                           lives_ff[idx_ext[SIDX_W-1:0]] <= req_ch.slot_life;
                        end
                     end
                     tbps_pkg::ACT_RESTART: begin
                        pos_ff <= '0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            S_MUL_ACT: begin
               active_ff <= {{SCNT_W{1'b0}}, bpw_eff} * {{BPW_W{1'b0}}, slot_eff};
               state_ff  <= S_MUL_PLAY;
            end
            S_MUL_PLAY: begin
               played_ff <= PLAY_W'(active_ff) * PLAY_W'(rep_plus);
               total_ff  <= TOT_W'(active_ff) + TOT_W'(cfg_dummy_ff);
               state_ff  <= S_CMP;
            end
            S_CMP: begin
               if (in_pattern) begin
                  state_ff <= S_DIV_BIT;
               end else if (in_round) begin
                  level_ff   <= cfg_dlevel_ff;
                  written_ff <= 1'b1;
                  pos_ff     <= pos_ff + POS_W'(1);
                  state_ff   <= S_FIN;
               end else begin
                  pos_ff  <= '0;
                  done_ff <= 1'b1;
                  for (int i = 0; i < SLOTS; i++) begin
                     if (32'(i) < 32'(slot_eff)) begin
                        if (lives_ff[i] == 8'd1) begin
                           lives_ff[i] <= '0;
                           words_ff[i] <= '0;
                        end else if (lives_ff[i] != '0) begin
                           lives_ff[i] <= lives_ff[i] - 8'd1;
                        end
                     end
                  end
                  state_ff <= S_FIN;
               end
            end
            S_DIV_BIT: begin
               if (div_done) begin
                  bitsel_ff <= bit_from_rem[BIDX_W-1:0];
                  state_ff  <= S_DIV_SLOT;
               end
            end
            S_DIV_SLOT: begin
               if (div_done) begin
                  level_ff   <= words_ff[div_rem[SIDX_W-1:0]][bitsel_ff];
                  written_ff <= 1'b1;
                  pos_ff     <= pos_ff + POS_W'(1);
                  state_ff   <= S_FIN;
               end
            end
            S_FIN: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_level_ff   <= level_ff;
                  rsp_written_ff <= written_ff;
                  rsp_done_ff    <= done_ff;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.pin_level   = rsp_level_ff;
   assign rsp_ch.pin_written = rsp_written_ff;
   assign rsp_ch.round_done  = rsp_done_ff;

endmodule
`default_nettype wire

@@ rtl/tbps_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tbps_checker
// Port-level checks on the sequencer core, bound to the core module.
// ----------------------------------------------------------------------------
module tbps_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_pin_level,
   input wire logic rsp_pin_written,
   input wire logic rsp_round_done
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !reset |=> rsp_valid)
      else $error("response dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready && !reset
         |=> $stable({rsp_pin_level, rsp_pin_written, rsp_round_done}))
      else $error("stalled response changed");

   a_done_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_round_done && rsp_pin_written))
      else $error("round end reported together with a pin write");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !reset |=> !req_ready)
      else $error("request taken while previous one in progress");

endmodule

bind timed_bit_pattern_sequencer_core tbps_checker u_tbps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_pin_level   (rsp_ch.pin_level),
   .rsp_pin_written (rsp_ch.pin_written),
   .rsp_round_done  (rsp_ch.round_done)
);
`default_nettype wire

@@ tb/tb_timed_bit_pattern_sequencer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timed_bit_pattern_sequencer_core
// Self-checking bench for the pattern sequencer. An opening table walks the
// reset state, the unused action code, restart, lifetime expiry, round ends,
// dummy states and a state time that never elapses. Eight register phases
// with random requests follow. The phases cover out-of-range widths and
// counts, and all-ones settings. Responses are checked against the table for typed rows
// and an in-bench model of the pin walk otherwise, with flow-control pressure in some phases.
// ----------------------------------------------------------------------------
module tb_timed_bit_pattern_sequencer_core;

   localparam int SEQ_SLOTS       = tbps_pkg::SLOTS_DEFAULT;
   localparam int SEQ_WORD_BITS   = tbps_pkg::WORD_BITS_DEFAULT;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 118;
   localparam int STALL_LIMIT     = 5000;
   localparam int DRAIN_CYCLES    = 50;
   localparam int OPENING_LEN     = 26;

   localparam logic [tbps_pkg::ACTION_W-1:0]  ACT_UNUSED   = 2'd3;
   localparam logic [tbps_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   // packed as {level, written, done}
   typedef struct packed {
      logic level;
      logic written;
      logic done;
   } pin_result_type;

   typedef enum bit {ROW_ITEM, ROW_REG} row_kind_type;

   // register rows carry the register index in idx and the data in word
   typedef struct packed {
      row_kind_type                     kind;
      logic [tbps_pkg::ACTION_W-1:0]    act;
      logic [tbps_pkg::SLOT_IDX_W-1:0]  idx;
      logic [tbps_pkg::SLOT_WORD_W-1:0] word;
      logic [tbps_pkg::SLOT_LIFE_W-1:0] life;
      bit                               typed;
      pin_result_type                   want;
   } stim_row_type;

   localparam stim_row_type OPENING_ROWS [OPENING_LEN] = '{
      '{ROW_ITEM, tbps_pkg::ACT_TICK, 3'd0, 32'h00000000, 8'h00, 1'b1, 3'b010},
      '{ROW_ITEM, tbps_pkg::ACT_WRITE, 3'd0, 32'hFFFFFFFF, 8'h00, 1'b1, 3'b000},
      '{ROW_ITEM, tbps_pkg::ACT_TICK, 3'd5, 32'hA5A5A5A5, 8'hFF, 1'b1, 3'b110},
      '{ROW_ITEM, ACT_UNUSED, 3'd7, 32'hFFFFFFFF, 8'hFF, 1'b1, 3'b100},
      '{ROW_ITEM, tbps_pkg::ACT_RESTART, 3'd7, 32'hFFFFFFFF, 8'hFF, 1'b1, 3'b100},
      '{ROW_ITEM, tbps_pkg::ACT_WRITE, 3'd7, 32'h00000000, 8'hFF, 1'b1, 3'b100},
      '{ROW_ITEM, tbps_pkg::ACT_WRITE, 3'd0, 32'h00000001, 8'h02, 1'b1, 3'b100},
      '{ROW_ITEM, tbps_pkg::ACT_TICK, 3'd2, 32'h5A5A5A5A, 8'h00, 1'b1, 3'b010},
      '{ROW_ITEM, tbps_pkg::ACT_TICK, 3'd0, 32'h00000000, 8'h00, 1'b0, 3'b000},
      '{ROW_REG, tbps_pkg::ACT_TICK, tbps_pkg::CSR_BITS_PER_WORD, 32'd1, 8'h00, 1'b0, 3'b000},
      '{ROW_REG, tbps_pkg::ACT_TICK, tbps_pkg::CSR_SLOT_COUNT, 32'd2, 8'h00, 1'b0, 3'b000},
      '{ROW_REG, tbps_pkg::ACT_TICK, tbps_pkg::CSR_DUMMY_COUNT, 32'd1, 8'h00, 1'b0, 3'b000},
      '{ROW_REG, tbps_pkg::ACT_TICK, tbps_pkg::CSR_DUMMY_LEVEL, 32'd1, 8'h00, 1'b0, 3'b000},
      '{ROW_REG, tbps_pkg::ACT_TICK, CSR_UNMAPPED, 32'hFFFFFFFF, 8'h00, 1'b0, 3'b000},
      '{ROW_ITEM, tbps_pkg::ACT_TICK, 3'd1, 32'h00000000, 8'h00, 1'b0, 3'b000},
      '{ROW_ITEM, tbps_pkg::ACT_TICK, 3'd6, 32'hFFFFFFFF, 8'hFF, 1'b0, 3'b000},
      '{ROW_ITEM, tbps_pkg::ACT_TICK, 3'd3, 32'h12345678, 8'h01, 1'b0, 3'b000},
      '{ROW_ITEM, tbps_pkg::ACT_TICK, 3'd4, 32'h80000000, 8'h80, 1'b0, 3'b000},
      '{ROW_ITEM, tbps_pkg::ACT_TICK, 3'd0, 32'h00000000, 8'h00, 1'b0, 3'b000},
      '{ROW_ITEM, tbps_pkg::ACT_TICK, 3'd0, 32'h00000000, 8'h00, 1'b0, 3'b000},
      '{ROW_REG, tbps_pkg::ACT_TICK, tbps_pkg::CSR_STATE_TICKS, 32'hFFFFFFFF, 8'h00, 1'b0,
        3'b000},
      '{ROW_ITEM, tbps_pkg::ACT_TICK, 3'd0, 32'h00000000, 8'h00, 1'b1, 3'b010},
      '{ROW_ITEM, tbps_pkg::ACT_TICK, 3'd0, 32'h00000000, 8'h00, 1'b1, 3'b000},
      '{ROW_ITEM, tbps_pkg::ACT_WRITE, 3'd3, 32'hFFFFFFFF, 8'h01, 1'b0, 3'b000},
      '{ROW_ITEM, tbps_pkg::ACT_WRITE, 3'd6, 32'h80000000, 8'h00, 1'b0, 3'b000},
      '{ROW_ITEM, tbps_pkg::ACT_RESTART, 3'd0, 32'h00000000, 8'h00, 1'b1, 3'b000}
   };

   logic clock;
   logic reset;

   tbps_req_if req_ch ();
   tbps_rsp_if rsp_ch ();
   tbps_csr_if csr_ch ();

   timed_bit_pattern_sequencer_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // model state
   logic [tbps_pkg::SLOT_WORD_W-1:0] slot_words_m [SEQ_SLOTS];
   logic [tbps_pkg::SLOT_LIFE_W-1:0] slot_lives_m [SEQ_SLOTS];
   int unsigned                      seq_pos;
   logic [31:0]                      seq_elapsed;
   logic                             seq_level;

   logic [tbps_pkg::BPW_CFG_W-1:0]   cfg_bpw;
   logic [tbps_pkg::SCNT_CFG_W-1:0]  cfg_slots;
   logic [tbps_pkg::REP_CFG_W-1:0]   cfg_repeat;
   logic [tbps_pkg::TICKS_CFG_W-1:0] cfg_ticks;
   logic [tbps_pkg::DUMMY_CFG_W-1:0] cfg_dummy;
   logic                             cfg_dlevel;

   pin_result_type expected_pins [$];

   int sender_idle_pct = 0;
   int recv_stall_pct  = 0;
   int stall_cycles    = 0;
   int n_items         = 0;
   int n_results       = 0;
   int n_reg_writes    = 0;
   int n_pin_writes    = 0;
   int n_rounds        = 0;
   int n_errors        = 0;

   function automatic int unsigned used_bits();
      int unsigned b;
      b = 32'(cfg_bpw);
      if (b == 0) b = 1;
      if (b > SEQ_WORD_BITS) b = SEQ_WORD_BITS;
      return b;
   endfunction

   function automatic int unsigned used_slots();
      int unsigned s;
      s = 32'(cfg_slots);
      if (s == 0) s = 1;
      if (s > SEQ_SLOTS) s = SEQ_SLOTS;
      return s;
   endfunction

   function automatic logic pattern_at(int unsigned p);
      int unsigned b;
      int unsigned s;
      int unsigned k;
      b = used_bits();
      s = (p / b) % used_slots();
      k = b - 1 - (p % b);
      return slot_words_m[s][k];
   endfunction

   function automatic pin_result_type sequence_step(
         logic [tbps_pkg::ACTION_W-1:0] act,
         logic [tbps_pkg::SLOT_IDX_W-1:0] idx,
         logic [tbps_pkg::SLOT_WORD_W-1:0] word,
         logic [tbps_pkg::SLOT_LIFE_W-1:0] life);
      pin_result_type res;
      int unsigned active;
      int unsigned played;
      int unsigned total;
      res = '0;
      case (act)
         tbps_pkg::ACT_TICK: begin
            active = used_bits() * used_slots();
            played = active * (32'(cfg_repeat) + 1);
            total  = active + 32'(cfg_dummy);
            if (seq_elapsed != '1) seq_elapsed++;
            if (seq_pos == 0) begin
               seq_elapsed = '0;
               seq_level   = pattern_at(0);
               res.written = 1'b1;
               seq_pos     = 1;
            end
            if (seq_elapsed > cfg_ticks) begin
               if (seq_pos < played) begin
                  seq_level   = pattern_at(seq_pos);
                  res.written = 1'b1;
                  seq_pos++;
               end else if (seq_pos < total) begin
                  seq_level   = cfg_dlevel;
                  res.written = 1'b1;
                  seq_pos++;
               end else begin
                  seq_pos  = 0;
                  res.done = 1'b1;
                  for (int i = 0; i < used_slots(); i++) begin
                     if (slot_lives_m[i] == 8'd1) begin
                        slot_lives_m[i] = '0;
                        slot_words_m[i] = '0;
                     end else if (slot_lives_m[i] != '0) begin
                        slot_lives_m[i]--;
                     end
                  end
               end
               seq_elapsed = '0;
            end
         end
         tbps_pkg::ACT_WRITE: begin
            slot_words_m[idx] = word;
            slot_lives_m[idx] = life;
         end
         tbps_pkg::ACT_RESTART: begin
            seq_pos = 0;
         end
         default: begin
         end
      endcase
      res.level = seq_level;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH result %0d: %s", $time, n_results, msg);
      n_errors++;
   endtask

   task automatic send_request(input logic [tbps_pkg::ACTION_W-1:0] act,
                               input logic [tbps_pkg::SLOT_IDX_W-1:0] idx,
                               input logic [tbps_pkg::SLOT_WORD_W-1:0] word,
                               input logic [tbps_pkg::SLOT_LIFE_W-1:0] life,
                               input bit typed,
                               input pin_result_type want);
      pin_result_type got;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.action     <= act;
      req_ch.slot_index <= idx;
      req_ch.slot_word  <= word;
      req_ch.slot_life  <= life;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      got = sequence_step(act, idx, word, life);
      expected_pins.push_back(typed ? want : got);
      n_items++;
   endtask

   task automatic write_reg(input logic [tbps_pkg::CSR_IDX_W-1:0] index,
                            input logic [tbps_pkg::CSR_DATA_W-1:0] data);
      // called in the step of the last request transfer, so this drops valid in time
      req_ch.valid <= 1'b0;
      while (expected_pins.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      case (index)
         tbps_pkg::CSR_BITS_PER_WORD: cfg_bpw    = data[tbps_pkg::BPW_CFG_W-1:0];
         tbps_pkg::CSR_SLOT_COUNT:    cfg_slots  = data[tbps_pkg::SCNT_CFG_W-1:0];
         tbps_pkg::CSR_REPEAT_COUNT:  cfg_repeat = data[tbps_pkg::REP_CFG_W-1:0];
         tbps_pkg::CSR_STATE_TICKS:   cfg_ticks  = data[tbps_pkg::TICKS_CFG_W-1:0];
         tbps_pkg::CSR_DUMMY_COUNT:   cfg_dummy  = data[tbps_pkg::DUMMY_CFG_W-1:0];
         tbps_pkg::CSR_DUMMY_LEVEL:   cfg_dlevel = data[0];
         default: begin
         end
      endcase
      n_reg_writes++;
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : result_check
      pin_result_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         n_results++;
         if (rsp_ch.pin_written === 1'b1) n_pin_writes++;
         if (rsp_ch.round_done === 1'b1) n_rounds++;
         if (expected_pins.size() == 0) begin
            report_mismatch("response with nothing outstanding");
         end else begin
            want = expected_pins.pop_front();
            if (rsp_ch.pin_level !== want.level)
               report_mismatch($sformatf("pin_level %b, want %b",
                                         rsp_ch.pin_level, want.level));
            if (rsp_ch.pin_written !== want.written)
               report_mismatch($sformatf("pin_written %b, want %b",
                                         rsp_ch.pin_written, want.written));
            if (rsp_ch.round_done !== want.done)
               report_mismatch($sformatf("round_done %b, want %b",
                                         rsp_ch.round_done, want.done));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[%0t] no transfer for %0d cycles, %0d responses outstanding",
                     $time, stall_cycles, expected_pins.size());
            $display("timed_bit_pattern_sequencer_core verification failed");
            $finish;
         end
      end
   end

   initial begin
      int unsigned                      counted;
      int                               r;
      logic [tbps_pkg::ACTION_W-1:0]    act;
      logic [tbps_pkg::BPW_CFG_W-1:0]   bpw;
      logic [tbps_pkg::SCNT_CFG_W-1:0]  scnt;
      logic [tbps_pkg::REP_CFG_W-1:0]   rep;
      logic [tbps_pkg::TICKS_CFG_W-1:0] ticks;
      logic [tbps_pkg::DUMMY_CFG_W-1:0] dummy;
      logic                             dlvl;

      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.action     <= tbps_pkg::ACT_TICK;
      req_ch.slot_index <= '0;
      req_ch.slot_word  <= '0;
      req_ch.slot_life  <= '0;
      csr_ch.valid      <= 1'b0;
      csr_ch.index      <= tbps_pkg::CSR_BITS_PER_WORD;
      csr_ch.data       <= '0;

      for (int i = 0; i < SEQ_SLOTS; i++) begin
         slot_words_m[i] = '0;
         slot_lives_m[i] = '0;
      end
      seq_pos     = 0;
      seq_elapsed = '0;
      seq_level   = 1'b0;
      cfg_bpw     = tbps_pkg::BPW_RESET;
      cfg_slots   = tbps_pkg::SCNT_RESET;
      cfg_repeat  = '0;
      cfg_ticks   = '0;
      cfg_dummy   = '0;
      cfg_dlevel  = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (OPENING_ROWS[i]) begin
         if (OPENING_ROWS[i].kind == ROW_REG)
            write_reg(OPENING_ROWS[i].idx, OPENING_ROWS[i].word);
         else
            send_request(OPENING_ROWS[i].act, OPENING_ROWS[i].idx, OPENING_ROWS[i].word,
                         OPENING_ROWS[i].life, OPENING_ROWS[i].typed, OPENING_ROWS[i].want);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin sender_idle_pct = 79; recv_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct = 79; end
            default: begin sender_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         case (phase)
            0: begin
               bpw = 6'd1;  scnt = 4'd1; rep = '0;   ticks = '0; dummy = '0; dlvl = 1'b1;
            end
            1: begin
               bpw = 6'd32; scnt = 4'd8; rep = '1;   ticks = '1; dummy = '1; dlvl = 1'b0;
            end
            2: begin
               bpw = '0;    scnt = '0;   rep = 8'd3; ticks = 32'd1; dummy = 16'd2; dlvl = 1'b1;
            end
            3: begin
               bpw = '1;    scnt = '1;   rep = '0;   ticks = '0; dummy = '0; dlvl = 1'b0;
            end
            default: begin
               bpw   = tbps_pkg::BPW_CFG_W'($urandom_range(0, 4));
               scnt  = tbps_pkg::SCNT_CFG_W'($urandom_range(0, 4));
               rep   = tbps_pkg::REP_CFG_W'($urandom_range(0, 2));
               ticks = tbps_pkg::TICKS_CFG_W'($urandom_range(0, 2));
               dummy = tbps_pkg::DUMMY_CFG_W'($urandom_range(0, 6));
               dlvl  = 1'($urandom_range(0, 1));
            end
         endcase
         // junk above each field width must be ignored
         write_reg(tbps_pkg::CSR_BITS_PER_WORD, ($urandom << tbps_pkg::BPW_CFG_W) | 32'(bpw));
         write_reg(tbps_pkg::CSR_SLOT_COUNT, ($urandom << tbps_pkg::SCNT_CFG_W) | 32'(scnt));
         write_reg(tbps_pkg::CSR_REPEAT_COUNT, ($urandom << tbps_pkg::REP_CFG_W) | 32'(rep));
         write_reg(tbps_pkg::CSR_STATE_TICKS, ticks);
         write_reg(tbps_pkg::CSR_DUMMY_COUNT, ($urandom << tbps_pkg::DUMMY_CFG_W) | 32'(dummy));
         write_reg(tbps_pkg::CSR_DUMMY_LEVEL, ($urandom << 1) | 32'(dlvl));

         counted = 0;
         while (counted < ITEMS_PER_PHASE) begin
            r = $urandom_range(99);
            if (r < 84)      act = tbps_pkg::ACT_TICK;
            else if (r < 96) act = tbps_pkg::ACT_WRITE;
            else if (r < 98) act = tbps_pkg::ACT_RESTART;
            else             act = ACT_UNUSED;
            send_request(act, tbps_pkg::SLOT_IDX_W'($urandom_range(7)), $urandom,
                         tbps_pkg::SLOT_LIFE_W'(($urandom_range(3) == 0) ?
                                                $urandom_range(255) : $urandom_range(3)),
                         1'b0, '0);
            if (act != ACT_UNUSED) counted++;
         end
      end

      req_ch.valid <= 1'b0;
      while (expected_pins.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests over %0d register phases with %0d register writes.",
               n_items, PHASES, n_reg_writes);
      $display("Checked %0d responses: %0d pin updates, %0d rounds ended, %0d mismatches.",
               n_results, n_pin_writes, n_rounds, n_errors);
      if (n_errors == 0) begin
         $display("timed_bit_pattern_sequencer_core verification clean");
      end else begin
         $display("timed_bit_pattern_sequencer_core verification failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/tbps_pkg.sv
rtl/tbps_if.sv
rtl/tbps_div.sv
rtl/timed_bit_pattern_sequencer_core.sv
rtl/tbps_checker.sv
tb/tb_timed_bit_pattern_sequencer_core.sv
